/* src/pcx_rle_scanline_encoder_unit_macros.svh */
// Assertion macros for the PCX run-length scanline encoder.
// Used by prle_core and prle_outq in src; no other dependencies.
// ASSERT_OFF compiles all assertions away.
`ifndef PCX_RLE_SCANLINE_ENCODER_UNIT_MACROS_SVH
`define PCX_RLE_SCANLINE_ENCODER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define PRLE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("prle assertion failed");
`define PRLE_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("prle forbidden condition seen");
`else
`define PRLE_ASSERT(label, clk, rst, prop)
`define PRLE_ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

/* src/prle_pkg.sv */
// Shared types and constants for the PCX run-length scanline encoder.
// No dependencies; imported by all modules of the block.
`default_nettype none

package prle_pkg;

   // request codes
   localparam logic REQ_DATA  = 1'b0;
   localparam logic REQ_FLUSH = 1'b1;

   localparam logic [5:0]  RUN_MAX        = 6'd63;
   localparam logic [7:0]  RUN_MARK       = 8'hC0;
   localparam logic [15:0] SCANLINE_RESET = 16'd80;

   // CSR map: one register, index taken from paddr[2]
   localparam int          CSR_ADDR_W     = 3;
   localparam logic        REG_SCANLINE   = 1'b0;

   // bytes produced by one request beat
   typedef struct packed {
      logic [1:0] cnt;    // 0, 1 or 2
      logic [7:0] byte0;
      logic [7:0] byte1;
   } emit_type;

endpackage

`default_nettype wire

/* src/prle_core.sv */
// Run tracking and coding logic of the PCX run-length encoder.
// Depends on prle_pkg and the assertion macro header.
`default_nettype none
`include "pcx_rle_scanline_encoder_unit_macros.svh"

module prle_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              req_type,
   input  wire logic [7:0]        data_byte,
   input  wire logic [15:0]       scanline_bytes,
   output prle_pkg::emit_type     emit
);
   import prle_pkg::*;

   logic [7:0]  run_value_ff,  run_value_in;
   logic [5:0]  run_length_ff, run_length_in;
   logic [15:0] column_ff,     column_in;
   logic        started_ff,    started_in;

   logic [15:0] col_sum;
   logic        col_wrap;
   logic        boundary;
   logic        extend;
   logic        use_mark;
   emit_type    pend;

   always_comb begin
      // pending run as coded bytes
      use_mark = (run_length_ff > 6'd2) || (run_value_ff >= RUN_MARK);
      pend.byte1 = run_value_ff;
      if (run_length_ff == 6'd0) begin
         pend.cnt   = 2'd0;
         pend.byte0 = run_value_ff;
      end else if (use_mark) begin
         pend.cnt   = 2'd2;
         pend.byte0 = RUN_MARK | {2'b00, run_length_ff};
      end else begin
         pend.cnt   = run_length_ff[1:0];
         pend.byte0 = run_value_ff;
      end

      col_sum  = column_ff + 16'd1;
      col_wrap = (scanline_bytes != 16'd0) && (col_sum >= scanline_bytes);
      boundary = started_ff && (column_ff == 16'd0);
      extend   = (run_length_ff < RUN_MAX) && (data_byte == run_value_ff) && !boundary;

      run_value_in  = run_value_ff;
      run_length_in = run_length_ff;
      column_in     = column_ff;
      started_in    = started_ff;
      emit          = '0;

      if (accept) begin
         if (req_type == REQ_FLUSH) begin
            emit          = pend;
            run_value_in  = 8'd0;
            run_length_in = 6'd0;
            column_in     = 16'd0;
            started_in    = 1'b0;
         end else begin
            if (extend) begin
               run_length_in = run_length_ff + 6'd1;
            end else begin
               emit          = pend;
               run_value_in  = data_byte;
               run_length_in = 6'd1;
            end
            column_in  = col_wrap ? 16'd0 : col_sum;
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= 8'd0;
         run_length_ff <= 6'd0;
         column_ff     <= 16'd0;
         started_ff    <= 1'b0;
      end else begin
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
         column_ff     <= column_in;
         started_ff    <= started_in;
      end
   end

   // a run is pending exactly when data arrived since reset or flush
   `PRLE_ASSERT(a_run_iff_started, clock, reset, (run_length_ff == 6'd0) == !started_ff)
   // an idle encoder sits at column zero
   `PRLE_ASSERT(a_idle_col_zero, clock, reset, !started_ff |-> (column_ff == 16'd0))

endmodule

`default_nettype wire

/* src/prle_outq.sv */
// Three-entry output queue for the coded byte stream, head is the result register.
// Depends on prle_pkg and the assertion macro header.
`default_nettype none
`include "pcx_rle_scanline_encoder_unit_macros.svh"

module prle_outq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  prle_pkg::emit_type     emit,
   output logic                   space,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last
);
   import prle_pkg::*;

   localparam int DEPTH = 3;

   logic [7:0] byte_ff [DEPTH];
   logic [7:0] byte_in [DEPTH];
   logic       last_ff [DEPTH];
   logic       last_in [DEPTH];
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic [1:0] base;
   logic [1:0] base_p1;

   assign rsp_valid    = (count_ff != 2'd0);
   assign rsp_out_byte = byte_ff[0];
   assign rsp_last     = last_ff[0];
   assign space        = (count_ff < 2'd2);

   always_comb begin
      pop     = rsp_valid && rsp_ready;
      base    = count_ff - {1'b0, pop};
      base_p1 = base + 2'd1;
      for (int i = 0; i < DEPTH; i++) begin
         byte_in[i] = byte_ff[i];
         last_in[i] = last_ff[i];
      end
      // head leaves, the rest shift down one slot
      if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            byte_in[i] = byte_ff[i + 1];
            last_in[i] = last_ff[i + 1];
         end
      end
      for (int i = 0; i < DEPTH; i++) begin
         if ((emit.cnt != 2'd0) && (2'(i) == base)) begin
            byte_in[i] = emit.byte0;
            last_in[i] = (emit.cnt == 2'd1);
         end
         if ((emit.cnt == 2'd2) && (2'(i) == base_p1)) begin
            byte_in[i] = emit.byte1;
            last_in[i] = 1'b1;
         end
      end
      count_in = base + emit.cnt;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         byte_ff[i] <= byte_in[i];
         last_ff[i] <= last_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // a push lands only when the queue had room for two bytes
   `PRLE_ASSERT_NEVER(a_no_overflow, clock, reset, (emit.cnt != 2'd0) && (count_ff > 2'd1))
   // a taken head with no push in the same cycle lowers the queue count by one
   `PRLE_ASSERT(a_pop_drains, clock, reset,
                (pop && emit.cnt == 2'd0) |=> (count_ff == $past(count_ff) - 2'd1))

endmodule

`default_nettype wire

/* src/pcx_rle_scanline_encoder_unit.sv */
// Top level of the PCX run-length scanline encoder: CSR block, run tracker, output queue.
// Depends on prle_pkg, prle_core, prle_outq.
//
// Usage:
//  - req channel: one beat per raw image byte (req_type = data) or a flush
//    (req_type = flush) that writes out the pending run and rewinds the encoder.
//  - rsp channel: coded bytes, 0 to 2 per request beat; rsp_last marks the
//    final byte caused by a request. Requests that close no run give no bytes.
//  - csr: APB-style, register 0 (scanline_bytes, 16 bits) at byte address 0.
//    Write it only while the encoder is idle. pready is tied high.
// Coded bytes are registered into the output queue when their request beat is accepted.
// Throughput: one request per cycle while each gives at most one byte and rsp is
//  not stalled; a request that gives a count/value pair puts two bytes in turn on
//  the byte-wide rsp port, so such requests cannot keep that rate.
// The run update is combinational logic ahead of the run registers; a three-entry output
// queue whose head is the rsp register decouples the sides. req_ready is registered: it
// drops once two or more bytes wait, so rsp stalls back up into req.
// Reset: scanline_bytes returns to 80, run state and queue are cleared.
`default_nettype none

module pcx_rle_scanline_encoder_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_type,
   input  wire logic [7:0]                     req_data_byte,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_last,
   // configuration
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [prle_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);
   import prle_pkg::*;

   logic [15:0] scanline_ff, scanline_in;
   logic        csr_wr;
   logic        req_accept;
   logic        q_space;
   emit_type    emit;

   // --- configuration register ---
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      scanline_in = scanline_ff;
      if (csr_wr && (csr_paddr[2] == REG_SCANLINE)) begin
         scanline_in = csr_pwdata[15:0];
      end
      // read mux; only index 0 exists
      if (csr_paddr[2] == REG_SCANLINE) begin
         csr_prdata = {16'd0, scanline_ff};
      end else begin
         csr_prdata = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scanline_ff <= SCANLINE_RESET;
      end else begin
         scanline_ff <= scanline_in;
      end
   end

   // --- request side ---
   assign req_ready  = q_space;
   assign req_accept = req_valid && req_ready;

   prle_core u_core (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .req_type       (req_type),
      .data_byte      (req_data_byte),
      .scanline_bytes (scanline_ff),
      .emit           (emit)
   );

   // --- response side ---
   prle_outq u_outq (
      .clock        (clock),
      .reset        (reset),
      .emit         (emit),
      .space        (q_space),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

/* test/tb_pcx_rle_scanline_encoder_unit.sv */
// Self-checking testbench for pcx_rle_scanline_encoder_unit: directed table, then random phases.
// Depends on prle_pkg and the RTL in src; coded bytes are checked against an in-bench encoder.
`default_nettype none

module tb_pcx_rle_scanline_encoder_unit;
   import prle_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int PHASE_ITEMS  = 235;
   localparam int N_PHASES     = 8;
   localparam int N_DIR        = 20;
   localparam int DRAIN_CYCLES = 8;   // margin for beats still in flight after the owed bytes are out
   localparam int LONG_HOLD    = 300;
   localparam logic [CSR_ADDR_W-1:0] SCANLINE_ADDR = CSR_ADDR_W'(4 * REG_SCANLINE);

   // one coded byte as it should leave on rsp
   typedef struct packed {
      logic [7:0] value;
      logic       is_last;
   } coded_type;

   // directed row: beat repeated reps times; when typed is set, the coded bytes of the
   // final repeat are given here (count, first, second) instead of by the encoder copy
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      int         reps;
      bit         typed;
      int         n;
      logic [7:0] b0;
      logic [7:0] b1;
   } dir_row_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_ready;
   logic                  req_type      = REQ_DATA;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_ready     = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [31:0]           csr_pwdata    = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // encoder copy: run state and scanline setting as the block should hold them
   logic [7:0]  enc_value;
   logic [5:0]  enc_len;
   logic [15:0] enc_col;
   logic        enc_started;
   logic [15:0] cfg_scanline;

   coded_type coded_bytes_q [$];   // coded bytes still owed by the block, oldest first

   int cycle_count   = 0;
   int err_count     = 0;
   bit no_idle       = 1'b0;    // both sides run flat out
   bit long_hold_req = 1'b0;    // asks the receiver for one long stall
   int hold_left     = 0;
   int stall_left    = 0;
   bit rdy_next;

   // Directed table, reset setting (80 bytes per scanline). Literal runs, pairs for
   // length 3+, pairs for values at or above the mark, full 63-byte run, flush corners.
   dir_row_type dir_rows [N_DIR] = '{
      '{REQ_FLUSH, 8'h5A,  1, 1'b1, 0, 8'h00, 8'h00},   // flush with nothing pending
      '{REQ_DATA,  8'h00,  1, 1'b1, 0, 8'h00, 8'h00},   // first byte equals reset value
      '{REQ_DATA,  8'h05,  1, 1'b1, 1, 8'h00, 8'h00},   // single literal out
      '{REQ_DATA,  8'h05,  1, 1'b1, 0, 8'h00, 8'h00},
      '{REQ_DATA,  8'h07,  1, 1'b1, 2, 8'h05, 8'h05},   // run of two: two literals
      '{REQ_DATA,  8'h07,  2, 1'b1, 0, 8'h00, 8'h00},
      '{REQ_DATA,  8'hFF,  1, 1'b1, 2, 8'hC3, 8'h07},   // run of three: pair
      '{REQ_DATA,  8'hFF,  1, 1'b1, 0, 8'h00, 8'h00},
      '{REQ_DATA,  8'hC0,  1, 1'b1, 2, 8'hC2, 8'hFF},   // high value, length two: pair
      '{REQ_DATA,  8'h00,  1, 1'b1, 2, 8'hC1, 8'hC0},   // high value, length one: pair
      '{REQ_FLUSH, 8'hA5,  1, 1'b1, 1, 8'h00, 8'h00},
      '{REQ_DATA,  8'hAA, 63, 1'b1, 0, 8'h00, 8'h00},   // fills a run to the limit
      '{REQ_DATA,  8'hAA,  1, 1'b1, 2, 8'hFF, 8'hAA},   // limit reached: run closed
      '{REQ_FLUSH, 8'h00,  1, 1'b1, 1, 8'hAA, 8'h00},
      '{REQ_DATA,  8'h80,  2, 1'b1, 0, 8'h00, 8'h00},
      '{REQ_FLUSH, 8'hFF,  1, 1'b1, 2, 8'h80, 8'h80},   // flush of a two-byte literal run
      '{REQ_DATA,  8'h3C,  4, 1'b0, 0, 8'h00, 8'h00},
      '{REQ_DATA,  8'h3D,  1, 1'b0, 0, 8'h00, 8'h00},
      '{REQ_FLUSH, 8'h77,  1, 1'b0, 0, 8'h00, 8'h00},
      '{REQ_FLUSH, 8'h01,  1, 1'b0, 0, 8'h00, 8'h00}    // back-to-back flush
   };

   pcx_rle_scanline_encoder_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // hard stop if the block hangs or drops bytes
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // idle length: mostly short, now and then long
   function automatic int idle_len();
      if ($urandom_range(99) < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic void clear_run();
      enc_value   = 8'h00;
      enc_len     = 6'd0;
      enc_col     = 16'd0;
      enc_started = 1'b0;
   endfunction

   // coded bytes of the pending run: pair for long or high-valued runs, else literals
   task automatic take_run(output int n, output logic [7:0] b0, output logic [7:0] b1);
      n  = 0;
      b0 = 8'h00;
      b1 = 8'h00;
      if (enc_len == 6'd0) begin
         n = 0;
      end else if (enc_len > 6'd2 || enc_value >= RUN_MARK) begin
         n  = 2;
         b0 = RUN_MARK | {2'b00, enc_len};
         b1 = enc_value;
      end else begin
         n  = int'(enc_len);
         b0 = enc_value;
         b1 = enc_value;
      end
   endtask

   // advances the encoder copy by one beat and returns the coded bytes it causes
   task automatic encode_beat(input logic kind, input logic [7:0] data,
                              output int n, output logic [7:0] b0, output logic [7:0] b1);
      logic        at_line_start;
      logic [15:0] next_col;
      n  = 0;
      b0 = 8'h00;
      b1 = 8'h00;
      if (kind == REQ_FLUSH) begin
         take_run(n, b0, b1);
         clear_run();
      end else begin
         // column 0 is a boundary only once the stream has started
         at_line_start = enc_started && enc_col == 16'd0;
         if (enc_len < RUN_MAX && data == enc_value && !at_line_start) begin
            enc_len = enc_len + 6'd1;
         end else begin
            take_run(n, b0, b1);
            enc_value = data;
            enc_len   = 6'd1;
         end
         // setting of zero: natural 16-bit wrap
         next_col = enc_col + 16'd1;
         if (cfg_scanline != 16'd0 && next_col >= cfg_scanline) next_col = 16'd0;
         enc_col     = next_col;
         enc_started = 1'b1;
      end
   endtask

   // Offers one beat, holds it until accepted, records the owed bytes, then may idle.
   // Entered and left just after a rising edge.
   task automatic offer_beat(input logic kind, input logic [7:0] data, input bit typed,
                             input int tn, input logic [7:0] t0, input logic [7:0] t1);
      int         n;
      logic [7:0] b0;
      logic [7:0] b1;
      int         gap;
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      encode_beat(kind, data, n, b0, b1);
      if (typed) begin
         n  = tn;
         b0 = t0;
         b1 = t1;
      end
      if (n >= 1) coded_bytes_q.insert(coded_bytes_q.size(), coded_type'{b0, (n == 1)});
      if (n == 2) coded_bytes_q.insert(coded_bytes_q.size(), coded_type'{b1, 1'b1});
      gap = (no_idle || $urandom_range(99) < 55) ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender stops until every owed byte is out, then waits out a margin for beats still in flight
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (coded_bytes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write of scanline_bytes followed by a read-back; only called while idle
   task automatic write_scanline(input logic [31:0] wdata);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= SCANLINE_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cfg_scanline = wdata[15:0];   // upper bits are dropped by the register
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {16'h0000, wdata[15:0]}) begin
         $error("prdata: expected %h, got %h", {16'h0000, wdata[15:0]}, csr_prdata);
         err_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Receiver: random stalls, one long counted hold on request, flat out when no_idle.
   always @(posedge clock) begin
      if (long_hold_req) begin
         hold_left     = LONG_HOLD;
         long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rdy_next = 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rdy_next = 1'b0;
      end else if (no_idle || $urandom_range(99) < 70) begin
         rdy_next = 1'b1;
      end else begin
         stall_left = idle_len() - 1;
         rdy_next   = 1'b0;
      end
      rsp_ready <= rdy_next;
   end

   // Checker: every accepted rsp beat against the oldest owed byte.
   always @(posedge clock) begin
      coded_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (coded_bytes_q.size() == 0) begin
            $error("out_byte: expected nothing, got %h (last %b)", rsp_out_byte, rsp_last);
            err_count++;
         end else begin
            want = coded_bytes_q.pop_front();
            if (rsp_out_byte !== want.value) begin
               $error("out_byte: expected %h, got %h", want.value, rsp_out_byte);
               err_count++;
            end
            if (rsp_last !== want.is_last) begin
               $error("last: expected %b, got %b", want.is_last, rsp_last);
               err_count++;
            end
         end
      end
   end

   // Stimulus: directed table, then random phases with a new scanline setting each.
   initial begin
      logic [15:0] scan_plan [N_PHASES];
      int          sent;
      int          run_len;
      int          pick;
      logic [7:0]  run_byte;
      bit          typed_here;

      clear_run();
      cfg_scanline = SCANLINE_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part; typed bytes apply to the final repeat of a row only
      for (int r = 0; r < N_DIR; r++) begin
         for (int k = 0; k < dir_rows[r].reps; k++) begin
            typed_here = dir_rows[r].typed && (k == dir_rows[r].reps - 1);
            offer_beat(dir_rows[r].kind, dir_rows[r].data, typed_here,
                       dir_rows[r].n, dir_rows[r].b0, dir_rows[r].b1);
         end
      end
      wait_idle();

      // settings: extremes, zero (16-bit wrap), tiny lines, and a large-then-small
      // pair so the column sits past the new boundary; no flush between phases
      scan_plan = '{16'd1, 16'd65535, 16'd2, 16'd0, 16'd80, 16'd3, 16'd5, 16'd7};
      scan_plan[4] = 16'($urandom_range(100, 8));
      scan_plan[6] = 16'($urandom_range(16, 4));

      for (int p = 0; p < N_PHASES; p++) begin
         write_scanline({16'($urandom_range(16'hFFFF)), scan_plan[p]});
         // one phase runs flat out, opening with a long rsp hold so the queue fills
         // and req_ready drops while beats keep coming
         no_idle = (p == 2);
         if (p == 2) long_hold_req = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
               offer_beat(REQ_FLUSH, 8'($urandom_range(255)), 1'b0, 0, 8'h00, 8'h00);
               sent++;
            end else if (pick < 14) begin
               offer_beat(REQ_DATA, 8'($urandom_range(255)), 1'b0, 0, 8'h00, 8'h00);
               sent++;
            end else begin
               // a run of equal bytes; values near the mark and the extremes favored
               case ($urandom_range(5))
                  0:       run_byte = 8'h00;
                  1:       run_byte = 8'hFF;
                  2:       run_byte = RUN_MARK;
                  3:       run_byte = RUN_MARK - 8'd1;
                  default: run_byte = 8'($urandom_range(255));
               endcase
               pick = $urandom_range(99);
               if (pick < 85)      run_len = $urandom_range(4, 1);
               else if (pick < 95) run_len = $urandom_range(20, 5);
               else                run_len = $urandom_range(70, 55);
               for (int j = 0; j < run_len && sent < PHASE_ITEMS; j++) begin
                  offer_beat(REQ_DATA, run_byte, 1'b0, 0, 8'h00, 8'h00);
                  sent++;
               end
            end
         end
         no_idle = 1'b0;
         wait_idle();
      end

      if (err_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
